[rtl/sbqc_pkg.sv]
package sbqc_pkg;

    // stream geometry
    localparam int SAMPLE_BITS       = 24;
    localparam int FILTERED_CHANNELS = 2;
    localparam int CHAN_W            = 3;
    localparam int CH_IDX_W          = (FILTERED_CHANNELS > 1) ? $clog2(FILTERED_CHANNELS) : 1;

    // arithmetic widths
    localparam int COEF_W  = 25;
    localparam int GAIN_W  = 24;
    localparam int SEC_W   = 36;
    localparam int DLY_W   = 40;
    localparam int PROD_W  = SEC_W + COEF_W;
    localparam int ACC_W   = 42;
    localparam int PB0_W   = PROD_W - 22;
    localparam int PB1_W   = PROD_W - 21;
    localparam int GPROD_W = PROD_W - 20;

    // configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [2:0] {
        REG_FIRST_B0    = 3'd0,
        REG_FIRST_A1    = 3'd1,
        REG_FIRST_A2    = 3'd2,
        REG_SECOND_B0   = 3'd3,
        REG_SECOND_A1   = 3'd4,
        REG_SECOND_A2   = 3'd5,
        REG_SECTION_MOD = 3'd6,
        REG_OUTPUT_GAIN = 3'd7
    } t_reg_idx;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'h100000;

    localparam logic [1:0] MODE_LOWPASS  = 2'd1;
    localparam logic [1:0] MODE_HIGHPASS = 2'd2;

    typedef struct packed {
        logic [COEF_W-1:0] first_b0;
        logic [COEF_W-1:0] first_a1;
        logic [COEF_W-1:0] first_a2;
        logic [COEF_W-1:0] second_b0;
        logic [COEF_W-1:0] second_a1;
        logic [COEF_W-1:0] second_a2;
        logic [3:0]        section_modes;
        logic [GAIN_W-1:0] output_gain;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEC_CHK,
        ST_MUL_B,
        ST_FORM_Y,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_UPD_D2,
        ST_MUL_G,
        ST_FINAL
    } t_state;

    typedef enum logic [1:0] {
        MSEL_B0,
        MSEL_A1,
        MSEL_A2,
        MSEL_GAIN
    } t_msel;

    typedef struct packed {
        logic  mul_en;
        t_msel mul_sel;
        logic  form_y;
        logic  upd_d1;
        logic  upd_d2;
        logic  next_sec;
        logic  out_load;
    } t_ctrl;

    // round half up of a coefficient product back to sample scale
    function automatic logic signed [PB0_W-1:0] rnd22(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + (PROD_W'(1) <<< 21);
        return t[PROD_W-1:22];
    endfunction

    // same product times two, rounded
    function automatic logic signed [PB1_W-1:0] rnd21(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + (PROD_W'(1) <<< 20);
        return t[PROD_W-1:21];
    endfunction

    function automatic logic signed [GPROD_W-1:0] rnd20(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + (PROD_W'(1) <<< 19);
        return t[PROD_W-1:20];
    endfunction

    function automatic logic signed [SEC_W-1:0] sat_sec(input logic signed [ACC_W-1:0] v);
        logic signed [SEC_W-1:0] r;
        if (v[ACC_W-1:SEC_W-1] == {(ACC_W-SEC_W+1){v[ACC_W-1]}}) begin
            r = v[SEC_W-1:0];
        end else begin
            r = v[ACC_W-1] ? {1'b1, {(SEC_W-1){1'b0}}} : {1'b0, {(SEC_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
        logic signed [DLY_W-1:0] r;
        if (v[ACC_W-1:DLY_W-1] == {(ACC_W-DLY_W+1){v[ACC_W-1]}}) begin
            r = v[DLY_W-1:0];
        end else begin
            r = v[ACC_W-1] ? {1'b1, {(DLY_W-1){1'b0}}} : {1'b0, {(DLY_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

[rtl/sbqc_if.sv]
interface sbqc_in_if;
    import sbqc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_in;
    logic [CHAN_W-1:0]      channel;
    logic                   restart;

    modport source (output valid, sample_in, channel, restart, input ready);
    modport sink   (input valid, sample_in, channel, restart, output ready);
endinterface

interface sbqc_out_if;
    import sbqc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_out;
    logic [CHAN_W-1:0]      channel_out;
    logic                   clipped;

    modport source (output valid, sample_out, channel_out, clipped, input ready);
    modport sink   (input valid, sample_out, channel_out, clipped, output ready);
endinterface

[rtl/stereo_biquad_cascade_filter.sv]
// sequence: a filtered sample gets, per active section, the b0 product, y, the a1
//   product, the a2 product with d1 update and the d2 update, then the gain product;
//   other channels go straight to the wait for a free output register. A new sample
//   waits for that load; one shared 36x25 multiplier does up to seven products in turn
// reset (i_rst_n low, synchronous): delay lines cleared, output empty, gain set to unity
module stereo_biquad_cascade_filter
    import sbqc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbqc_in_if.sink           i_in,
    sbqc_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    t_cfg s_cfg;

    sbqc_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (s_cfg)
    );

    // no wait states on the config port
    assign pready = 1'b1;

    // ---------------------------------------------------------------
    // sequencer and item registers
    // ---------------------------------------------------------------
    t_state r_state, n_state;
    t_ctrl  s_ctrl;

    logic                    r_sec;      // section in work: 0 first, 1 second
    logic [CHAN_W-1:0]       r_ch;
    logic                    r_filt;     // channel goes through the filter
    logic signed [SEC_W-1:0] r_x;        // section input, then section output y
    logic signed [PB0_W-1:0] r_pb0;
    logic signed [PB1_W-1:0] r_pb1;

    // per-section, per-channel delay lines
    logic signed [DLY_W-1:0] r_d1 [2][FILTERED_CHANNELS];
    logic signed [DLY_W-1:0] r_d2 [2][FILTERED_CHANNELS];

    // output register
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic [CHAN_W-1:0]      r_out_ch;
    logic                   r_out_clip;

    logic s_accept;
    logic s_out_free;
    logic s_sec_active;
    logic s_in_filt;
    logic [1:0] s_mode;
    logic [CH_IDX_W-1:0] s_cidx;

    assign i_in.ready = (r_state == ST_IDLE);
    assign s_accept   = i_in.valid && i_in.ready;
    assign s_out_free = !r_out_valid || o_out.ready;
    assign s_in_filt  = ({1'b0, i_in.channel} < (CHAN_W+1)'(FILTERED_CHANNELS));
    assign s_cidx     = r_ch[CH_IDX_W-1:0];

    // mode of the section in work; codes other than lowpass/highpass bypass it
    assign s_mode       = r_sec ? s_cfg.section_modes[3:2] : s_cfg.section_modes[1:0];
    assign s_sec_active = (s_mode == MODE_LOWPASS) || (s_mode == MODE_HIGHPASS);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = s_in_filt ? ST_SEC_CHK : ST_FINAL;
                end
            end
            ST_SEC_CHK: begin
                if (s_sec_active) begin
                    n_state = ST_MUL_B;
                end else if (r_sec) begin
                    n_state = ST_MUL_G;
                end
            end
            ST_MUL_B:  n_state = ST_FORM_Y;
            ST_FORM_Y: n_state = ST_MUL_A1;
            ST_MUL_A1: n_state = ST_MUL_A2;
            ST_MUL_A2: n_state = ST_UPD_D2;
            ST_UPD_D2: n_state = r_sec ? ST_MUL_G : ST_SEC_CHK;
            ST_MUL_G:  n_state = ST_FINAL;
            ST_FINAL: begin
                if (s_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // control decode
    always_comb begin
        s_ctrl = '0;
        s_ctrl.mul_sel = MSEL_B0;
        case (r_state)
            ST_SEC_CHK: s_ctrl.next_sec = !s_sec_active && !r_sec;
            ST_MUL_B: begin
                s_ctrl.mul_en  = 1'b1;
                s_ctrl.mul_sel = MSEL_B0;
            end
            ST_FORM_Y:  s_ctrl.form_y = 1'b1;
            ST_MUL_A1: begin
                s_ctrl.mul_en  = 1'b1;
                s_ctrl.mul_sel = MSEL_A1;
            end
            ST_MUL_A2: begin
                s_ctrl.mul_en  = 1'b1;
                s_ctrl.mul_sel = MSEL_A2;
                s_ctrl.upd_d1  = 1'b1;
            end
            ST_UPD_D2: begin
                s_ctrl.upd_d2   = 1'b1;
                s_ctrl.next_sec = !r_sec;
            end
            ST_MUL_G: begin
                s_ctrl.mul_en  = 1'b1;
                s_ctrl.mul_sel = MSEL_GAIN;
            end
            ST_FINAL:   s_ctrl.out_load = s_out_free;
            default:    s_ctrl = s_ctrl;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // shared multiplier: operand a is always the working value r_x
    // ---------------------------------------------------------------
    logic signed [COEF_W-1:0] s_mul_b;
    logic signed [PROD_W-1:0] s_prod;

    always_comb begin
        case (s_ctrl.mul_sel)
            MSEL_B0:   s_mul_b = r_sec ? s_cfg.second_b0 : s_cfg.first_b0;
            MSEL_A1:   s_mul_b = r_sec ? s_cfg.second_a1 : s_cfg.first_a1;
            MSEL_A2:   s_mul_b = r_sec ? s_cfg.second_a2 : s_cfg.first_a2;
            MSEL_GAIN: s_mul_b = {s_cfg.output_gain[GAIN_W-1], s_cfg.output_gain};
            default:   s_mul_b = '0;
        endcase
    end

    sbqc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (s_ctrl.mul_en),
        .i_a    (r_x),
        .i_b    (s_mul_b),
        .o_prod (s_prod)
    );

    // ---------------------------------------------------------------
    // section arithmetic
    // ---------------------------------------------------------------
    logic signed [PB0_W-1:0] s_pb0;
    logic signed [PB1_W-1:0] s_pb1;
    logic signed [PB0_W-1:0] s_pa;
    logic signed [DLY_W-1:0] s_d1_cur;
    logic signed [DLY_W-1:0] s_d2_cur;
    logic signed [SEC_W-1:0] s_y;
    logic signed [DLY_W-1:0] s_d1_new;
    logic signed [DLY_W-1:0] s_d2_new;
    logic signed [PB1_W-1:0] s_pb1_sgn;

    assign s_d1_cur = r_d1[r_sec][s_cidx];
    assign s_d2_cur = r_d2[r_sec][s_cidx];

    // b1 = +2*b0 for lowpass, -2*b0 for highpass
    assign s_pb0 = rnd22(s_prod);
    assign s_pb1 = rnd21(s_prod);
    assign s_pb1_sgn = (s_mode == MODE_HIGHPASS) ? rnd21(-s_prod) : s_pb1;

    // r(a*y) for the feedback terms
    assign s_pa = rnd22(s_prod);

    // y = sat36(r(b0*x) + d1)
    assign s_y = sat_sec({{(ACC_W-PB0_W){s_pb0[PB0_W-1]}}, s_pb0}
                       + {{(ACC_W-DLY_W){s_d1_cur[DLY_W-1]}}, s_d1_cur});

    // d1' = sat40(r(b1*x) - r(a1*y) + d2)
    assign s_d1_new = sat_dly({{(ACC_W-PB1_W){r_pb1[PB1_W-1]}}, r_pb1}
                            - {{(ACC_W-PB0_W){s_pa[PB0_W-1]}}, s_pa}
                            + {{(ACC_W-DLY_W){s_d2_cur[DLY_W-1]}}, s_d2_cur});

    // d2' = sat40(r(b0*x) - r(a2*y))
    assign s_d2_new = sat_dly({{(ACC_W-PB0_W){r_pb0[PB0_W-1]}}, r_pb0}
                            - {{(ACC_W-PB0_W){s_pa[PB0_W-1]}}, s_pa});

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x    <= {{(SEC_W-SAMPLE_BITS){i_in.sample_in[SAMPLE_BITS-1]}}, i_in.sample_in};
            r_ch   <= i_in.channel;
            r_filt <= s_in_filt;
        end else if (s_ctrl.form_y) begin
            r_x   <= s_y;
            r_pb0 <= s_pb0;
            r_pb1 <= s_pb1_sgn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec <= 1'b0;
        end else if (s_accept) begin
            r_sec <= 1'b0;
        end else if (s_ctrl.next_sec) begin
            r_sec <= 1'b1;
        end
    end

    // delay lines: cleared on reset and on a restart transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s_accept && i_in.restart)) begin
            for (int s = 0; s < 2; s++) begin
                for (int c = 0; c < FILTERED_CHANNELS; c++) begin
                    r_d1[s][c] <= '0;
                    r_d2[s][c] <= '0;
                end
            end
        end else begin
            if (s_ctrl.upd_d1) begin
                r_d1[r_sec][s_cidx] <= s_d1_new;
            end
            if (s_ctrl.upd_d2) begin
                r_d2[r_sec][s_cidx] <= s_d2_new;
            end
        end
    end

    // ---------------------------------------------------------------
    // output gain, rounding, saturation
    // ---------------------------------------------------------------
    logic signed [GPROD_W-1:0]     s_g;
    logic signed [SAMPLE_BITS-1:0] s_final;
    logic                          s_clip;

    assign s_g = rnd20(s_prod);

    always_comb begin
        s_clip  = 1'b0;
        s_final = r_x[SAMPLE_BITS-1:0];
        if (r_filt) begin
            if (s_g[GPROD_W-1:SAMPLE_BITS-1] == {(GPROD_W-SAMPLE_BITS+1){s_g[GPROD_W-1]}}) begin
                s_final = s_g[SAMPLE_BITS-1:0];
            end else begin
                s_clip  = 1'b1;
                s_final = s_g[GPROD_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ctrl.out_load) begin
            r_out_sample <= s_final;
            r_out_ch     <= r_ch;
            r_out_clip   <= s_clip;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.sample_out  = r_out_sample;
    assign o_out.channel_out = r_out_ch;
    assign o_out.clipped     = r_out_clip;

endmodule

[rtl/sbqc_mul.sv]
module sbqc_mul
    import sbqc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [SEC_W-1:0]  i_a,
    input  logic signed [COEF_W-1:0] i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

[rtl/sbqc_regs.sv]
module sbqc_regs
    import sbqc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx s_idx;
    logic     s_wr;

    assign s_idx = t_reg_idx'(i_paddr[APB_AW-1:2]);
    assign s_wr  = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg             <= '0;
            r_cfg.output_gain <= GAIN_RESET;
        end else if (s_wr) begin
            case (s_idx)
                REG_FIRST_B0:    r_cfg.first_b0      <= i_pwdata[COEF_W-1:0];
                REG_FIRST_A1:    r_cfg.first_a1      <= i_pwdata[COEF_W-1:0];
                REG_FIRST_A2:    r_cfg.first_a2      <= i_pwdata[COEF_W-1:0];
                REG_SECOND_B0:   r_cfg.second_b0     <= i_pwdata[COEF_W-1:0];
                REG_SECOND_A1:   r_cfg.second_a1     <= i_pwdata[COEF_W-1:0];
                REG_SECOND_A2:   r_cfg.second_a2     <= i_pwdata[COEF_W-1:0];
                REG_SECTION_MOD: r_cfg.section_modes <= i_pwdata[3:0];
                REG_OUTPUT_GAIN: r_cfg.output_gain   <= i_pwdata[GAIN_W-1:0];
                default:         r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (s_idx)
            REG_FIRST_B0:    o_prdata = APB_DW'(r_cfg.first_b0);
            REG_FIRST_A1:    o_prdata = APB_DW'(r_cfg.first_a1);
            REG_FIRST_A2:    o_prdata = APB_DW'(r_cfg.first_a2);
            REG_SECOND_B0:   o_prdata = APB_DW'(r_cfg.second_b0);
            REG_SECOND_A1:   o_prdata = APB_DW'(r_cfg.second_a1);
            REG_SECOND_A2:   o_prdata = APB_DW'(r_cfg.second_a2);
            REG_SECTION_MOD: o_prdata = APB_DW'(r_cfg.section_modes);
            REG_OUTPUT_GAIN: o_prdata = APB_DW'(r_cfg.output_gain);
            default:         o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/sbqc_checker.sv]
module sbqc_checker
    import sbqc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_sample,
    input logic [CHAN_W-1:0]      i_out_channel,
    input logic                   i_out_clipped
);

    localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // one item in flight: no second transaction right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted twice in a row");

    // a clipped result sits at a rail of the sample range
    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_clipped) |-> (i_out_sample == SMAX || i_out_sample == SMIN))
        else $error("clipped result not saturated");

    // pass-through channels never clip
    a_pass_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && ({1'b0, i_out_channel} >= (CHAN_W+1)'(FILTERED_CHANNELS)))
        |-> !i_out_clipped)
        else $error("unfiltered channel flagged clipped");

    // output empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // a waiting result is held
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind stereo_biquad_cascade_filter sbqc_checker u_sbqc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_sample  (o_out.sample_out),
    .i_out_channel (o_out.channel_out),
    .i_out_clipped (o_out.clipped)
);

[sim/tb_stereo_biquad_cascade_filter.sv]
module tb_stereo_biquad_cascade_filter;
    import sbqc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // run limits
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int SETTLE_CYCLES  = 20;      // idle wait after the last expected output
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 250;
    localparam int STEADY_PHASE   = 3;       // phase run with no idling on either side

    // fixed point scales
    localparam int COEF_FRAC = 22;
    localparam int GAIN_FRAC = 20;
    localparam int Q22       = 1 << COEF_FRAC;

    // section mode codes not named by the package
    localparam logic [1:0] MODE_BYPASS     = 2'd0;
    localparam logic [1:0] MODE_BYPASS_ALT = 2'd3;

    // coefficient and gain extremes
    localparam int COEF_MAX = 16777215;
    localparam int COEF_MIN = -16777216;
    localparam int GAIN_MAX = 8388607;
    localparam int GAIN_MIN = -8388608;
    localparam int GAIN_ONE = 1048576;

    // a low cutoff lowpass and a matching highpass, both stable
    localparam int PRESET_A1    = -6547405;
    localparam int PRESET_A2    = 2688549;
    localparam int PRESET_LP_B0 = 83886;
    localparam int PRESET_HP_B0 = 3355443;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [CHAN_W-1:0]      ch;
        logic                   clipped;
    } t_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    sbqc_in_if  in_if();
    sbqc_out_if out_if();

    stereo_biquad_cascade_filter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the register file and of the per channel delay lines
    t_cfg   model_cfg;
    longint first_z1  [FILTERED_CHANNELS];
    longint first_z2  [FILTERED_CHANNELS];
    longint second_z1 [FILTERED_CHANNELS];
    longint second_z2 [FILTERED_CHANNELS];

    // output samples still owed by the block, oldest first
    t_result pending_samples[$];

    int err_count;
    bit steady_flow;

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // overall watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_stereo_biquad_cascade_filter: errors");
        $finish;
    end

    // output side backpressure, ready low about 29 percent of the time outside the steady phase
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= steady_flow || ($urandom_range(0, 99) >= 29);
        end
    end

    function automatic void log_failure(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%s", what);
        end
    endfunction

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // round half up, then floor, of v / 2^sh
    function automatic longint round_q(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_bits(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic void clear_delays();
        for (int c = 0; c < FILTERED_CHANNELS; c++) begin
            first_z1[c]  = 0;
            first_z2[c]  = 0;
            second_z1[c] = 0;
            second_z2[c] = 0;
        end
    endfunction

    // one transposed direct form ii section; bypass modes leave the state alone
    function automatic longint run_section(input longint x, input logic [1:0] mode,
                                           input logic [COEF_W-1:0] rb0,
                                           input logic [COEF_W-1:0] ra1,
                                           input logic [COEF_W-1:0] ra2,
                                           inout longint z1, inout longint z2);
        longint b0, a1, a2, b1, pb0, pb1, y;
        if (mode != MODE_LOWPASS && mode != MODE_HIGHPASS) return x;
        b0  = longint'($signed(rb0));
        a1  = longint'($signed(ra1));
        a2  = longint'($signed(ra2));
        b1  = (mode == MODE_LOWPASS) ? 2 * b0 : -2 * b0;
        pb0 = round_q(b0 * x, COEF_FRAC);
        pb1 = round_q(b1 * x, COEF_FRAC);
        y   = clamp_bits(pb0 + z1, SEC_W);
        z1  = clamp_bits(pb1 - round_q(a1 * y, COEF_FRAC) + z2, DLY_W);
        z2  = clamp_bits(pb0 - round_q(a2 * y, COEF_FRAC), DLY_W);
        return y;
    endfunction

    // works out the result of one accepted sample and queues it
    function automatic void filter_sample(input logic [SAMPLE_BITS-1:0] smp,
                                          input logic [CHAN_W-1:0] ch, input logic rst);
        t_result res;
        longint  y;
        longint  g;
        longint  scaled;
        logic [CH_IDX_W-1:0] idx;
        if (rst) clear_delays();
        y           = longint'($signed(smp));
        res.ch      = ch;
        res.clipped = 1'b0;
        if (ch < FILTERED_CHANNELS) begin
            idx = ch[CH_IDX_W-1:0];
            y = run_section(y, model_cfg.section_modes[1:0], model_cfg.first_b0,
                            model_cfg.first_a1, model_cfg.first_a2,
                            first_z1[idx], first_z2[idx]);
            y = run_section(y, model_cfg.section_modes[3:2], model_cfg.second_b0,
                            model_cfg.second_a1, model_cfg.second_a2,
                            second_z1[idx], second_z2[idx]);
            g      = longint'($signed(model_cfg.output_gain));
            scaled = round_q(y * g, GAIN_FRAC);
            y      = clamp_bits(scaled, SAMPLE_BITS);
            res.clipped = (y != scaled);
        end
        res.sample = SAMPLE_BITS'(y);
        pending_samples.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // register shadow helpers
    // ------------------------------------------------------------------

    function automatic logic [APB_DW-1:0] reg_mask(input t_reg_idx idx);
        case (idx)
            REG_SECTION_MOD: return 32'hF;
            REG_OUTPUT_GAIN: return (32'd1 << GAIN_W) - 1;
            default:         return (32'd1 << COEF_W) - 1;
        endcase
    endfunction

    function automatic logic [APB_DW-1:0] reg_value(input t_reg_idx idx);
        case (idx)
            REG_FIRST_B0:    return 32'(model_cfg.first_b0);
            REG_FIRST_A1:    return 32'(model_cfg.first_a1);
            REG_FIRST_A2:    return 32'(model_cfg.first_a2);
            REG_SECOND_B0:   return 32'(model_cfg.second_b0);
            REG_SECOND_A1:   return 32'(model_cfg.second_a1);
            REG_SECOND_A2:   return 32'(model_cfg.second_a2);
            REG_SECTION_MOD: return 32'(model_cfg.section_modes);
            default:         return 32'(model_cfg.output_gain);
        endcase
    endfunction

    function automatic void shadow_write(input t_reg_idx idx, input logic [APB_DW-1:0] word);
        case (idx)
            REG_FIRST_B0:    model_cfg.first_b0      = word[COEF_W-1:0];
            REG_FIRST_A1:    model_cfg.first_a1      = word[COEF_W-1:0];
            REG_FIRST_A2:    model_cfg.first_a2      = word[COEF_W-1:0];
            REG_SECOND_B0:   model_cfg.second_b0     = word[COEF_W-1:0];
            REG_SECOND_A1:   model_cfg.second_a1     = word[COEF_W-1:0];
            REG_SECOND_A2:   model_cfg.second_a2     = word[COEF_W-1:0];
            REG_SECTION_MOD: model_cfg.section_modes = word[3:0];
            default:         model_cfg.output_gain   = word[GAIN_W-1:0];
        endcase
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------

    // unused upper data bits carry noise, the register keeps only its own width
    task automatic apb_write(input t_reg_idx idx, input int value);
        logic [APB_DW-1:0] word;
        word = (32'(value) & reg_mask(idx)) | ($urandom() & ~reg_mask(idx));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_write(idx, word);
        // bus left idle before the next transfer
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input t_reg_idx idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if ((prdata & reg_mask(idx)) !== reg_value(idx)) begin
            log_failure($sformatf("register %s: expected %h, got %h",
                                  idx.name(), reg_value(idx), prdata & reg_mask(idx)));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        // bus left idle before the next transfer
        @(posedge i_clk);
    endtask

    task automatic check_all_registers();
        for (int r = 0; r < 8; r++) begin
            apb_read_check(t_reg_idx'(r));
        end
    endtask

    // programs every register, then reads them all back
    task automatic load_filter(input int b0_one, input int a1_one, input int a2_one,
                               input int b0_two, input int a1_two, input int a2_two,
                               input logic [3:0] modes, input int gain);
        apb_write(REG_FIRST_B0, b0_one);
        apb_write(REG_FIRST_A1, a1_one);
        apb_write(REG_FIRST_A2, a2_one);
        apb_write(REG_SECOND_B0, b0_two);
        apb_write(REG_SECOND_A1, a1_two);
        apb_write(REG_SECOND_A2, a2_two);
        apb_write(REG_SECTION_MOD, int'(modes));
        apb_write(REG_OUTPUT_GAIN, gain);
        check_all_registers();
    endtask

    // ------------------------------------------------------------------
    // sample stream
    // ------------------------------------------------------------------

    // one input transaction, with random idle cycles in front outside the steady phase
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp,
                               input logic [CHAN_W-1:0] ch, input logic rst);
        if (!steady_flow) begin
            while ($urandom_range(0, 99) < 29) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid     <= 1'b1;
        in_if.sample_in <= smp;
        in_if.channel   <= ch;
        in_if.restart   <= rst;
        do @(posedge i_clk); while (!in_if.ready);
        filter_sample(smp, ch, rst);
    endtask

    // block idle: nothing owed and the pipeline had time to settle
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // compare each output transaction against the oldest prediction
    always @(posedge i_clk) begin : check_output
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_samples.size() == 0) begin
                log_failure($sformatf("unexpected output: sample %h ch %0d clipped %b",
                                      out_if.sample_out, out_if.channel_out, out_if.clipped));
            end else begin
                want = pending_samples.pop_front();
                if (out_if.sample_out !== want.sample || out_if.channel_out !== want.ch ||
                    out_if.clipped !== want.clipped) begin
                    log_failure($sformatf(
                        "mismatch: expected sample %h ch %0d clipped %b, got %h ch %0d clipped %b",
                        want.sample, want.ch, want.clipped,
                        out_if.sample_out, out_if.channel_out, out_if.clipped));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // random stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_BITS'($urandom_range(0, 2000) - 1000);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // mostly the two filtered channels, the rest spread over all eight
    function automatic logic [CHAN_W-1:0] pick_channel();
        if ($urandom_range(0, 9) < 7) return CHAN_W'($urandom_range(0, 1));
        return CHAN_W'($urandom_range(0, 7));
    endfunction

    function automatic int random_sign(input int mag);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // poles kept inside the stability triangle: |a2| < 1, |a1| < 1 + a2
    task automatic pick_stable(output int b0, output int a1, output int a2);
        a2 = int'($urandom_range(Q22 * 3 / 10, Q22 * 98 / 100));
        a1 = random_sign(int'($urandom_range(0, Q22 + a2 - 1)));
        b0 = random_sign(int'($urandom_range(0, Q22 / 2)));
    endtask

    function automatic int pick_extreme_coef();
        return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 3))
            0:       return GAIN_ONE;
            1:       return int'($urandom_range(GAIN_ONE / 4, GAIN_ONE * 2));
            2:       return int'($urandom_range(0, GAIN_MAX)) - int'($urandom_range(0, GAIN_MAX));
            default: return $urandom_range(0, 1) ? GAIN_MAX : GAIN_MIN;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values read back, and a unity gain bypass leaves samples as they are
    task automatic test_reset_state();
        check_all_registers();
        send_sample(SAMPLE_MAX, 3'd0, 1'b0);
        send_sample(SAMPLE_MIN, 3'd1, 1'b0);
    endtask

    // channels past the filtered ones bypass the filter and gain, also on a restart transaction
    task automatic test_unfiltered_channels();
        wait_idle();
        load_filter(PRESET_LP_B0, PRESET_A1, PRESET_A2, PRESET_HP_B0, PRESET_A1, PRESET_A2,
                    {MODE_HIGHPASS, MODE_LOWPASS}, GAIN_MAX);
        send_sample(SAMPLE_MAX, 3'd2, 1'b0);
        send_sample(SAMPLE_MIN, 3'd3, 1'b0);
        send_sample(SAMPLE_BITS'(24'h5A5A5A), 3'd4, 1'b1);
        send_sample(SAMPLE_BITS'(24'hA5A5A5), 3'd5, 1'b0);
        send_sample(SAMPLE_BITS'(0), 3'd6, 1'b0);
        send_sample(SAMPLE_MAX, 3'd7, 1'b1);
    endtask

    // output gain extremes with both sections bypassed, clipping both ways
    task automatic test_gain_extremes();
        wait_idle();
        load_filter(0, 0, 0, 0, 0, 0, {MODE_BYPASS_ALT, MODE_BYPASS}, GAIN_MAX);
        send_sample(SAMPLE_MAX, 3'd0, 1'b0);
        send_sample(SAMPLE_BITS'(24'h000100), 3'd1, 1'b0);
        wait_idle();
        apb_write(REG_OUTPUT_GAIN, GAIN_MIN);
        send_sample(SAMPLE_MIN, 3'd0, 1'b0);
        send_sample(SAMPLE_MAX, 3'd1, 1'b0);
        wait_idle();
        apb_write(REG_OUTPUT_GAIN, 0);
        send_sample(SAMPLE_MAX, 3'd0, 1'b0);
    endtask

    // lowpass and highpass responses, channels kept apart, restart clears both
    task automatic test_filter_modes();
        wait_idle();
        load_filter(PRESET_LP_B0, PRESET_A1, PRESET_A2, PRESET_LP_B0, PRESET_A1, PRESET_A2,
                    {MODE_LOWPASS, MODE_LOWPASS}, GAIN_ONE);
        send_sample(SAMPLE_BITS'(24'h400000), 3'd0, 1'b1);
        send_sample(SAMPLE_MAX, 3'd1, 1'b0);
        send_sample(SAMPLE_BITS'(0), 3'd0, 1'b0);
        send_sample(SAMPLE_MAX, 3'd1, 1'b0);
        send_sample(SAMPLE_BITS'(0), 3'd0, 1'b0);
        send_sample(SAMPLE_MAX, 3'd1, 1'b0);
        wait_idle();
        load_filter(PRESET_HP_B0, PRESET_A1, PRESET_A2, PRESET_LP_B0, PRESET_A1, PRESET_A2,
                    {MODE_BYPASS_ALT, MODE_HIGHPASS}, GAIN_ONE);
        send_sample(SAMPLE_MIN, 3'd0, 1'b0);
        send_sample(SAMPLE_BITS'(24'h123456), 3'd1, 1'b1);
        send_sample(SAMPLE_MAX, 3'd0, 1'b0);
    endtask

    // extreme coefficients drive section and delay saturation
    task automatic test_internal_saturation();
        wait_idle();
        load_filter(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN,
                    {MODE_HIGHPASS, MODE_LOWPASS}, GAIN_MAX);
        send_sample(SAMPLE_MAX, 3'd0, 1'b0);
        send_sample(SAMPLE_MIN, 3'd0, 1'b0);
        send_sample(SAMPLE_MAX, 3'd1, 1'b0);
        send_sample(SAMPLE_MIN, 3'd0, 1'b0);
    endtask

    // phases of random settings, each followed by a random interleaved stream
    task automatic test_random_stream();
        int b0_one, a1_one, a2_one, b0_two, a1_two, a2_two;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            case (phase % 4)
                0: begin
                    pick_stable(b0_one, a1_one, a2_one);
                    pick_stable(b0_two, a1_two, a2_two);
                end
                1: begin
                    b0_one = $urandom_range(0, 1) ? PRESET_LP_B0 : PRESET_HP_B0;
                    b0_two = $urandom_range(0, 1) ? PRESET_LP_B0 : PRESET_HP_B0;
                    a1_one = PRESET_A1;
                    a2_one = PRESET_A2;
                    a1_two = PRESET_A1;
                    a2_two = PRESET_A2;
                end
                2: begin
                    // arbitrary coefficients, mostly unstable
                    b0_one = int'($urandom_range(0, COEF_MAX)) + COEF_MIN / 2;
                    a1_one = int'($urandom_range(0, COEF_MAX)) + COEF_MIN / 2;
                    a2_one = int'($urandom_range(0, COEF_MAX)) + COEF_MIN / 2;
                    b0_two = int'($urandom_range(0, COEF_MAX)) + COEF_MIN / 2;
                    a1_two = int'($urandom_range(0, COEF_MAX)) + COEF_MIN / 2;
                    a2_two = int'($urandom_range(0, COEF_MAX)) + COEF_MIN / 2;
                end
                default: begin
                    b0_one = pick_extreme_coef();
                    a1_one = pick_extreme_coef();
                    a2_one = pick_extreme_coef();
                    b0_two = pick_extreme_coef();
                    a1_two = pick_extreme_coef();
                    a2_two = pick_extreme_coef();
                end
            endcase
            load_filter(b0_one, a1_one, a2_one, b0_two, a1_two, a2_two,
                        4'($urandom_range(0, 15)), pick_gain());
            steady_flow = (phase == STEADY_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(pick_sample(), pick_channel(), $urandom_range(0, 99) < 3);
            end
            steady_flow = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        err_count   = 0;
        steady_flow = 1'b0;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.sample_in <= '0;
        in_if.channel   <= '0;
        in_if.restart   <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;

        // shadow reset state: zero coefficients, bypass, unity gain
        model_cfg             = '0;
        model_cfg.output_gain = GAIN_RESET;
        clear_delays();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_unfiltered_channels();
        test_gain_extremes();
        test_filter_modes();
        test_internal_saturation();
        test_random_stream();

        wait_idle();
        if (pending_samples.size() != 0) begin
            log_failure($sformatf("%0d expected samples never arrived",
                                  pending_samples.size()));
        end
        if (err_count == 0) begin
            $display("tb_stereo_biquad_cascade_filter: clean");
        end else begin
            $display("tb_stereo_biquad_cascade_filter: errors");
        end
        $finish;
    end

endmodule
